// ----- hdl/ledw_pkg.sv -----
// shared types and constants for the two-wire led display writer
package ledw_pkg;

  localparam int unsigned MAX_DIGITS = 4;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned DIG_IDX_W  = $clog2(MAX_DIGITS);

  // input transaction kinds
  localparam logic MODE_TICK    = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_BRIGHTNESS      = 3'd0;
  localparam logic [2:0] CFG_DISPLAY_ON      = 3'd1;
  localparam logic [2:0] CFG_DATA_COMMAND    = 3'd2;
  localparam logic [2:0] CFG_ADDRESS_COMMAND = 3'd3;
  localparam logic [2:0] CFG_CONTROL_COMMAND = 3'd4;

  // reset values of the command bytes
  localparam logic [7:0] DATA_CMD_RST = 8'h40;
  localparam logic [7:0] ADDR_CMD_RST = 8'hC0;
  localparam logic [7:0] CTRL_CMD_RST = 8'h80;

  // frame indexes
  localparam logic [1:0] FRAME_DATA = 2'd0;
  localparam logic [1:0] FRAME_ADDR = 2'd1;
  localparam logic [1:0] FRAME_CTRL = 2'd2;

  // pin phase sequencer states
  typedef enum logic [4:0] {
    PH_IDLE = 5'd0,
    PH_S0   = 5'd1,
    PH_S1   = 5'd2,
    PH_S2   = 5'd3,
    PH_S3   = 5'd4,
    PH_B0   = 5'd5,
    PH_B1   = 5'd6,
    PH_B2   = 5'd7,
    PH_A0   = 5'd8,
    PH_A1   = 5'd9,
    PH_A2   = 5'd10,
    PH_A3   = 5'd11,
    PH_A4   = 5'd12,
    PH_P0   = 5'd13,
    PH_P1   = 5'd14,
    PH_P2   = 5'd15,
    PH_P3   = 5'd16
  } phase_t;

  // one result transaction
  typedef struct packed {
    logic clk_out;
    logic dio_out;
    logic dio_drive;
    logic busy_res;
    logic ack_missing;
    logic done_res;
  } res_t;

endpackage

// ----- hdl/led_display_two_wire_writer_top.sv -----
// two-wire led display write master, one pin phase per tick transaction
//
// usage:
//   input channel (in_valid / in_stall): in_mode 1 is a write request that
//   latches four segment bytes, a byte count (saturated at four) and a start
//   digit; in_mode 0 is a tick that advances the pin sequencer by one phase.
//   three frames go out: data command, address command plus start digit with
//   the segment bytes, control command plus brightness and on bit.
//   requests while busy and ticks while idle leave the state untouched.
//   result channel (out_valid / out_stall): one result per input transaction
//   carrying the line levels after that transaction, busy, ack and done.
//   config port (cfg_valid / cfg_ready): always ready, index selects one of
//   brightness, display_on, data_command, address_command, control_command;
//   other indexes are dropped. write only while idle.
// timing: result registered; one transaction per cycle sustained unless
//   out_stall holds it, set by the single registered sequencer state update.
// stall: a two-entry output (result register plus skid register) lets the
//   block take one more transaction while a result waits; in_stall rises
//   only when both entries are full.
// reset: synchronous rst_n puts lines idle high, sequencer idle, config to
//   defaults and empties the output stages.
module led_display_two_wire_writer_top
  import ledw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic       in_dio_in,
  input  logic [7:0] in_segment_0,
  input  logic [7:0] in_segment_1,
  input  logic [7:0] in_segment_2,
  input  logic [7:0] in_segment_3,
  input  logic [2:0] in_digit_count,
  input  logic [1:0] in_start_digit,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_clk_out,
  output logic       out_dio_out,
  output logic       out_dio_drive,
  output logic       out_busy_res,
  output logic       out_ack_missing,
  output logic       out_done_res,
  // config port
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  // config registers
  logic [2:0] brightness_r;
  logic       display_on_r;
  logic [7:0] data_cmd_r;
  logic [7:0] addr_cmd_r;
  logic [7:0] ctrl_cmd_r;

  // sequencer state
  phase_t             phase_r, phase_nxt;
  logic [1:0]         frame_r, frame_nxt;
  logic [CNT_W-1:0]   sent_r, sent_nxt;
  logic [2:0]         bit_r, bit_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic [CNT_W-1:0]   wanted_r, wanted_nxt;
  logic [1:0]         first_addr_r, first_addr_nxt;
  logic               clk_lvl_r, clk_lvl_nxt;
  logic               dio_lvl_r, dio_lvl_nxt;
  logic               dio_drv_r, dio_drv_nxt;
  logic               ack_r, ack_nxt;
  logic               done_nxt;

  // segment byte store, written whole on each request accepted while idle
  logic [7:0] digit_store_r [MAX_DIGITS];

  // output stages
  logic out_v_r, skid_v_r;
  res_t out_r, skid_r, res_nxt;

  logic       in_acc;
  logic       out_acc;
  logic       start_req;
  logic       tick_adv;
  logic [2:0] bit_inc;
  logic       more_digits;
  logic [7:0] frame_byte;
  logic [3:0] ctrl_nib;
  logic [CNT_W-1:0] count_sat;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_v_r;
  assign in_acc    = in_valid & ~skid_v_r;
  assign out_acc   = out_v_r & ~out_stall;

  assign start_req = in_acc & (in_mode == MODE_REQUEST) & (phase_r == PH_IDLE);
  assign tick_adv  = in_acc & (in_mode == MODE_TICK) & (phase_r != PH_IDLE);

  assign bit_inc     = bit_r + 3'd1;
  assign more_digits = (frame_r == FRAME_ADDR) && (sent_r < wanted_r);
  assign ctrl_nib    = {display_on_r, brightness_r};
  assign count_sat   = (in_digit_count > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS)
                                                             : in_digit_count;

  // command byte of the current frame
  always_comb begin
    unique case (frame_r)
      FRAME_DATA: frame_byte = data_cmd_r;
      FRAME_ADDR: frame_byte = addr_cmd_r + {6'd0, first_addr_r};
      default:    frame_byte = ctrl_cmd_r + {4'd0, ctrl_nib};
    endcase
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (start_req) begin
      phase_nxt = PH_S0;
    end else if (tick_adv) begin
      unique case (phase_r)
        PH_S0:   phase_nxt = PH_S1;
        PH_S1:   phase_nxt = PH_S2;
        PH_S2:   phase_nxt = PH_S3;
        PH_S3:   phase_nxt = PH_B0;
        PH_B0:   phase_nxt = PH_B1;
        PH_B1:   phase_nxt = PH_B2;
        PH_B2:   phase_nxt = (bit_inc == 3'd0) ? PH_A0 : PH_B0;
        PH_A0:   phase_nxt = PH_A1;
        PH_A1:   phase_nxt = PH_A2;
        PH_A2:   phase_nxt = PH_A3;
        PH_A3:   phase_nxt = PH_A4;
        PH_A4:   phase_nxt = more_digits ? PH_B0 : PH_P0;
        PH_P0:   phase_nxt = PH_P1;
        PH_P1:   phase_nxt = PH_P2;
        PH_P2:   phase_nxt = PH_P3;
        PH_P3:   phase_nxt = (frame_r >= FRAME_CTRL) ? PH_IDLE : PH_S0;
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // pin levels, counters and shifter for this phase
  always_comb begin
    frame_nxt      = frame_r;
    sent_nxt       = sent_r;
    bit_nxt        = bit_r;
    shift_nxt      = shift_r;
    wanted_nxt     = wanted_r;
    first_addr_nxt = first_addr_r;
    clk_lvl_nxt    = clk_lvl_r;
    dio_lvl_nxt    = dio_lvl_r;
    dio_drv_nxt    = dio_drv_r;
    ack_nxt        = ack_r;
    done_nxt       = 1'b0;
    if (start_req) begin
      wanted_nxt     = count_sat;
      first_addr_nxt = in_start_digit;
      frame_nxt      = FRAME_DATA;
      sent_nxt       = '0;
      bit_nxt        = '0;
    end else if (tick_adv) begin
      if (phase_r == PH_A3) begin
        ack_nxt = in_dio_in;
      end
      unique case (phase_r)
        PH_S0: begin
          dio_drv_nxt = 1'b1;
          dio_lvl_nxt = 1'b1;
        end
        PH_S1: clk_lvl_nxt = 1'b1;
        PH_S2: dio_lvl_nxt = 1'b0;
        PH_S3: begin
          clk_lvl_nxt = 1'b0;
          shift_nxt   = frame_byte;
          bit_nxt     = '0;
        end
        PH_B0: clk_lvl_nxt = 1'b0;
        PH_B1: dio_lvl_nxt = shift_r[0];
        PH_B2: begin
          clk_lvl_nxt = 1'b1;
          shift_nxt   = {1'b0, shift_r[7:1]};
          bit_nxt     = bit_inc;
        end
        PH_A0: clk_lvl_nxt = 1'b0;
        PH_A1: dio_lvl_nxt = 1'b1;
        PH_A2: clk_lvl_nxt = 1'b1;
        PH_A3: dio_drv_nxt = 1'b0;
        PH_A4: begin
          // re-drive at the sampled ack level
          dio_drv_nxt = 1'b1;
          dio_lvl_nxt = ack_r;
          if (more_digits) begin
            shift_nxt = digit_store_r[sent_r[DIG_IDX_W-1:0]];
            sent_nxt  = sent_r + CNT_W'(1);
            bit_nxt   = '0;
          end
        end
        PH_P0: begin
          dio_drv_nxt = 1'b1;
          clk_lvl_nxt = 1'b0;
        end
        PH_P1: dio_lvl_nxt = 1'b0;
        PH_P2: clk_lvl_nxt = 1'b1;
        PH_P3: begin
          dio_lvl_nxt = 1'b1;
          if (frame_r >= FRAME_CTRL) begin
            frame_nxt = FRAME_DATA;
            done_nxt  = 1'b1;
          end else begin
            frame_nxt = frame_r + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_nxt.clk_out     = clk_lvl_nxt;
    res_nxt.dio_out     = dio_lvl_nxt;
    res_nxt.dio_drive   = dio_drv_nxt;
    res_nxt.busy_res    = (phase_nxt != PH_IDLE);
    res_nxt.ack_missing = ack_nxt;
    res_nxt.done_res    = done_nxt;
  end

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= '0;
      display_on_r <= 1'b0;
      data_cmd_r   <= DATA_CMD_RST;
      addr_cmd_r   <= ADDR_CMD_RST;
      ctrl_cmd_r   <= CTRL_CMD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BRIGHTNESS:      brightness_r <= cfg_data[2:0];
        CFG_DISPLAY_ON:      display_on_r <= cfg_data[0];
        CFG_DATA_COMMAND:    data_cmd_r   <= cfg_data;
        CFG_ADDRESS_COMMAND: addr_cmd_r   <= cfg_data;
        CFG_CONTROL_COMMAND: ctrl_cmd_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      frame_r      <= FRAME_DATA;
      sent_r       <= '0;
      bit_r        <= '0;
      shift_r      <= '0;
      wanted_r     <= '0;
      first_addr_r <= '0;
      clk_lvl_r    <= 1'b1;
      dio_lvl_r    <= 1'b1;
      dio_drv_r    <= 1'b1;
      ack_r        <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      frame_r      <= frame_nxt;
      sent_r       <= sent_nxt;
      bit_r        <= bit_nxt;
      shift_r      <= shift_nxt;
      wanted_r     <= wanted_nxt;
      first_addr_r <= first_addr_nxt;
      clk_lvl_r    <= clk_lvl_nxt;
      dio_lvl_r    <= dio_lvl_nxt;
      dio_drv_r    <= dio_drv_nxt;
      ack_r        <= ack_nxt;
    end
  end

  // segment store, no reset
  always_ff @(posedge clk) begin
    if (start_req) begin
      digit_store_r[0] <= in_segment_0;
      digit_store_r[1] <= in_segment_1;
      digit_store_r[2] <= in_segment_2;
      digit_store_r[3] <= in_segment_3;
    end
  end

  // output register plus skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (skid_v_r) begin
        if (out_acc) begin
          skid_v_r <= 1'b0;
        end
      end else if (in_acc) begin
        if (out_v_r && !out_acc) begin
          skid_v_r <= 1'b1;
        end else begin
          out_v_r <= 1'b1;
        end
      end else if (out_acc) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_acc) begin
        out_r <= skid_r;
      end
    end else if (in_acc) begin
      if (out_v_r && !out_acc) begin
        skid_r <= res_nxt;
      end else begin
        out_r <= res_nxt;
      end
    end
  end

  assign out_valid       = out_v_r;
  assign out_clk_out     = out_r.clk_out;
  assign out_dio_out     = out_r.dio_out;
  assign out_dio_drive   = out_r.dio_drive;
  assign out_busy_res    = out_r.busy_res;
  assign out_ack_missing = out_r.ack_missing;
  assign out_done_res    = out_r.done_res;

  // skid entry only ever backs up a full result register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register full while result register empty");

  // the data line is only released in phase PH_A4, the acknowledge slot
  a_release_in_ack: assert property (@(posedge clk) disable iff (!rst_n)
    !dio_drv_r |-> (phase_r == PH_A4))
    else $error("data line released outside acknowledge slot");

  // idle sequencer always sits on the first frame
  a_idle_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (frame_r == FRAME_DATA))
    else $error("idle with nonzero frame number");

  // done only on the tick that ends the control frame stop
  a_done_leaves_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_adv && done_nxt) |=> (phase_r == PH_IDLE))
    else $error("done flagged without returning to idle");

endmodule

// ----- test/ledw_line_checker.sv -----
// line-level predictor and result checker for the two-wire led display writer
module ledw_line_checker
  import ledw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_mode,
  input  logic       in_dio_in,
  input  logic [7:0] in_segment_0,
  input  logic [7:0] in_segment_1,
  input  logic [7:0] in_segment_2,
  input  logic [7:0] in_segment_3,
  input  logic [2:0] in_digit_count,
  input  logic [1:0] in_start_digit,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_clk_out,
  input  logic       out_dio_out,
  input  logic       out_dio_drive,
  input  logic       out_busy_res,
  input  logic       out_ack_missing,
  input  logic       out_done_res,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         pending,
  output logic       seq_busy,
  output int         writes_done,
  output int         acks_missing
);

  localparam logic [CNT_W-1:0] DIGIT_CAP = CNT_W'(MAX_DIGITS);
  localparam int MAX_PRINTED = 40;

  // register copies
  logic [2:0] brightness = 3'd0;
  logic       disp_on    = 1'b0;
  logic [7:0] data_cmd   = DATA_CMD_RST;
  logic [7:0] addr_cmd   = ADDR_CMD_RST;
  logic [7:0] ctrl_cmd   = CTRL_CMD_RST;

  // sequencer copy
  phase_t           phase = PH_IDLE;
  logic [1:0]       frame_no;
  logic [2:0]       bytes_sent, bit_no, digits_wanted;
  logic [7:0]       shift_byte;
  logic [7:0]       digit_store [4];
  logic [1:0]       first_addr;
  logic             clk_lvl, dio_lvl, dio_drv, ack_flag;

  res_t  line_levels_q [$];
  int    results_checked;
  string field_name [6] = '{"clk_out", "dio_out", "dio_drive", "busy_res",
                            "ack_missing", "done_res"};

  assign seq_busy = (phase != PH_IDLE);

  task automatic report(input string msg);
    if (fail_count < MAX_PRINTED) $display("mismatch: %s", msg);
    fail_count++;
  endtask

  function automatic logic [7:0] frame_byte();
    case (frame_no)
      FRAME_DATA: return data_cmd;
      FRAME_ADDR: return addr_cmd + {6'd0, first_addr};
      default:    return ctrl_cmd + {4'd0, disp_on, brightness};
    endcase
  endfunction

  task automatic load_byte(input logic [7:0] b);
    shift_byte = b;
    bit_no     = 3'd0;
    phase      = PH_B0;
  endtask

  // one pin action of the sequencer
  task automatic advance_phase(output logic done);
    logic [7:0] b;
    done = 1'b0;
    case (phase)
      PH_S0: begin dio_drv = 1'b1; dio_lvl = 1'b1; phase = PH_S1; end
      PH_S1: begin clk_lvl = 1'b1; phase = PH_S2; end
      PH_S2: begin dio_lvl = 1'b0; phase = PH_S3; end
      PH_S3: begin clk_lvl = 1'b0; load_byte(frame_byte()); end
      PH_B0: begin clk_lvl = 1'b0; phase = PH_B1; end
      PH_B1: begin dio_lvl = shift_byte[0]; phase = PH_B2; end
      PH_B2: begin
        clk_lvl    = 1'b1;
        shift_byte = shift_byte >> 1;
        bit_no     = bit_no + 3'd1;
        phase      = (bit_no == 3'd0) ? PH_A0 : PH_B0;
      end
      PH_A0: begin clk_lvl = 1'b0; phase = PH_A1; end
      PH_A1: begin dio_lvl = 1'b1; phase = PH_A2; end
      PH_A2: begin clk_lvl = 1'b1; phase = PH_A3; end
      PH_A3: begin dio_drv = 1'b0; phase = PH_A4; end
      PH_A4: begin
        // line driven again at the sampled ack level
        dio_drv = 1'b1;
        dio_lvl = ack_flag;
        if (frame_no == FRAME_ADDR && bytes_sent < digits_wanted) begin
          b          = digit_store[bytes_sent[1:0]];
          bytes_sent = bytes_sent + 3'd1;
          load_byte(b);
        end else begin
          phase = PH_P0;
        end
      end
      PH_P0: begin dio_drv = 1'b1; clk_lvl = 1'b0; phase = PH_P1; end
      PH_P1: begin dio_lvl = 1'b0; phase = PH_P2; end
      PH_P2: begin clk_lvl = 1'b1; phase = PH_P3; end
      PH_P3: begin
        dio_lvl = 1'b1;
        if (frame_no >= FRAME_CTRL) begin
          frame_no = FRAME_DATA;
          phase    = PH_IDLE;
          done     = 1'b1;
        end else begin
          frame_no = frame_no + 2'd1;
          phase    = PH_S0;
        end
      end
      default: phase = PH_IDLE;
    endcase
  endtask

  task automatic predict_lines(input logic mode, input logic dio,
                               input logic [7:0] s0, s1, s2, s3,
                               input logic [2:0] cnt, input logic [1:0] start,
                               output res_t r);
    logic done;
    done = 1'b0;
    if (mode == MODE_REQUEST) begin
      // requests while busy are dropped
      if (phase == PH_IDLE) begin
        digit_store[0] = s0;
        digit_store[1] = s1;
        digit_store[2] = s2;
        digit_store[3] = s3;
        digits_wanted  = (cnt > DIGIT_CAP) ? DIGIT_CAP : cnt;
        first_addr     = start;
        frame_no       = FRAME_DATA;
        bytes_sent     = 3'd0;
        bit_no         = 3'd0;
        phase          = PH_S0;
      end
    end else if (phase != PH_IDLE) begin
      if (phase == PH_A3) begin
        ack_flag = dio;
        if (dio) acks_missing++;
      end
      advance_phase(done);
    end
    if (done) writes_done++;
    r.clk_out     = clk_lvl;
    r.dio_out     = dio_lvl;
    r.dio_drive   = dio_drv;
    r.busy_res    = (phase != PH_IDLE);
    r.ack_missing = ack_flag;
    r.done_res    = done;
  endtask

  always @(posedge clk) begin
    res_t want, got;
    if (!rst_n) begin
      brightness = 3'd0;
      disp_on    = 1'b0;
      data_cmd   = DATA_CMD_RST;
      addr_cmd   = ADDR_CMD_RST;
      ctrl_cmd   = CTRL_CMD_RST;
      phase      = PH_IDLE;
      frame_no   = FRAME_DATA;
      bytes_sent = 3'd0;
      bit_no     = 3'd0;
      shift_byte = 8'd0;
      digits_wanted = 3'd0;
      first_addr = 2'd0;
      clk_lvl    = 1'b1;
      dio_lvl    = 1'b1;
      dio_drv    = 1'b1;
      ack_flag   = 1'b0;
      line_levels_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BRIGHTNESS:      brightness = cfg_data[2:0];
          CFG_DISPLAY_ON:      disp_on    = cfg_data[0];
          CFG_DATA_COMMAND:    data_cmd   = cfg_data;
          CFG_ADDRESS_COMMAND: addr_cmd   = cfg_data;
          CFG_CONTROL_COMMAND: ctrl_cmd   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_lines(in_mode, in_dio_in, in_segment_0, in_segment_1, in_segment_2,
                      in_segment_3, in_digit_count, in_start_digit, want);
        line_levels_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = {out_clk_out, out_dio_out, out_dio_drive, out_busy_res,
               out_ack_missing, out_done_res};
        if (line_levels_q.size() == 0) begin
          report($sformatf("result %0d arrived with nothing expected", results_checked));
        end else begin
          want = line_levels_q.pop_front();
          for (int i = 0; i < 6; i++) begin
            if (got[5-i] !== want[5-i])
              report($sformatf("result %0d field %s got %b expected %b",
                               results_checked, field_name[i], got[5-i], want[5-i]));
          end
        end
        results_checked++;
      end
    end
    pending = line_levels_q.size();
  end

endmodule

// ----- test/tb_top.sv -----
// testbench top: stimulus, idling mixes, watchdog and verdict for the led display writer
module tb_top
  import ledw_pkg::*;
();

  // an index past the register list, writes to it must be dropped
  localparam logic [2:0] CFG_UNUSED_IDX = 3'd5;
  localparam int PHASE_ITEMS   = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 4;

  logic       clk   = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_mode  = 1'b0;
  logic       in_dio_in = 1'b0;
  logic [7:0] in_segment_0 = 8'd0;
  logic [7:0] in_segment_1 = 8'd0;
  logic [7:0] in_segment_2 = 8'd0;
  logic [7:0] in_segment_3 = 8'd0;
  logic [2:0] in_digit_count = 3'd0;
  logic [1:0] in_start_digit = 2'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_clk_out, out_dio_out, out_dio_drive;
  logic       out_busy_res, out_ack_missing, out_done_res;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = 3'd0;
  logic [7:0] cfg_data  = 8'd0;

  // from the checker
  int   fail_count, pending, writes_done, acks_missing;
  logic seq_busy;

  // idling knobs, percent of cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // long hold-off handshake between the main flow and the receiver
  int holds_asked = 0;
  int holds_given = 0;
  int hold_left   = 0;

  int offered    = 0;
  int settings   = 1;
  int idle_count = 0;

  led_display_two_wire_writer_top dut (.*);
  ledw_line_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver side: random stall, or a long hold-off when one is asked for
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (holds_asked != holds_given) begin
      out_stall <= 1'b1;
      hold_left = HOLD_CYCLES - 1;
      holds_given = holds_given + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // watchdog: too many cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                  (cfg_valid && cfg_ready)))
      idle_count = 0;
    else
      idle_count = idle_count + 1;
    if (idle_count >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // offer one input transaction and wait until it is taken;
  // valid stays high on return, callers that pause must lower it
  task automatic offer(input logic mode, input logic dio,
                       input logic [7:0] s0, s1, s2, s3,
                       input logic [2:0] cnt, input logic [1:0] start);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_mode        <= mode;
    in_dio_in      <= dio;
    in_segment_0   <= s0;
    in_segment_1   <= s1;
    in_segment_2   <= s2;
    in_segment_3   <= s3;
    in_digit_count <= cnt;
    in_start_digit <= start;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
    offered++;
    @(negedge clk);
  endtask

  // tick with junk in the request-only fields
  task automatic tick(input logic dio);
    offer(MODE_TICK, dio, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
          3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
  endtask

  // clock out the running sequence; nack_pct sets how often dio reads high,
  // and now and then a request lands mid-sequence and must be dropped
  task automatic tick_until_idle(input int nack_pct);
    while (seq_busy) begin
      if ($urandom_range(0, 99) < 2)
        offer(MODE_REQUEST, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
              2'($urandom_range(0, 3)));
      tick($urandom_range(0, 99) < nack_pct);
    end
  endtask

  task automatic run_write(input logic [7:0] s0, s1, s2, s3,
                           input logic [2:0] cnt, input logic [1:0] start,
                           input int nack_pct);
    offer(MODE_REQUEST, 1'($urandom_range(0, 1)), s0, s1, s2, s3, cnt, start);
    tick_until_idle(nack_pct);
  endtask

  // finish any sequence, drain every result, then leave a short quiet gap
  task automatic settle();
    tick_until_idle(0);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // one config transaction per register (plus one to an unused index when stray
  // is set), upper data bits filled with junk where the register is narrower than the data bus
  task automatic write_settings(input logic [2:0] bright, input logic on,
                                input logic [7:0] dcmd, acmd, ccmd, input bit stray);
    logic [2:0] idx [6];
    logic [7:0] val [6];
    logic [7:0] junk;
    int n;
    junk = 8'($urandom_range(0, 255));
    idx = '{CFG_BRIGHTNESS, CFG_DISPLAY_ON, CFG_DATA_COMMAND, CFG_ADDRESS_COMMAND,
            CFG_CONTROL_COMMAND, CFG_UNUSED_IDX};
    val = '{{junk[7:3], bright}, {junk[7:1], on}, dcmd, acmd, ccmd, ~junk};
    if (stray) idx[5] = idx[5] + 3'($urandom_range(0, 2));
    n = stray ? 6 : 5;
    for (int i = 0; i < n; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  initial begin
    int phase_start;
    int nack_pick [4];
    nack_pick = '{0, 10, 50, 100};

    // reset held low from the start, released on a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, reset settings, no idling
    // ticks while idle must leave the lines at rest
    tick(1'b0);
    tick(1'b1);
    // count above four saturates, top start digit, all-ones segments,
    // plus a request straight after that the busy block must drop
    offer(MODE_REQUEST, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7, 2'd3);
    offer(MODE_REQUEST, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 3'd2, 2'd0);
    tick_until_idle(30);
    // count zero: address frame with the address byte alone
    run_write(8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 2'd0, 0);
    // exactly four, every ack missing
    run_write(8'hA5, 8'h5A, 8'h3C, 8'hC3, 3'd4, 2'd2, 100);
    run_write(8'h81, 8'h7E, 8'h00, 8'hFF, 3'd1, 2'd1, 0);

    // random part: a new register setting and idling mix per phase
    for (int p = 1; p < 7; p++) begin
      settle();
      case (p)
        1: write_settings(3'd0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1);
        2: write_settings(3'd7, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        default: write_settings(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), p == 3);
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      // long receiver hold-off while the sender keeps pushing
      if (p == 5) holds_asked = holds_asked + 1;
      phase_start = offered;
      while (offered - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 15)
          repeat ($urandom_range(1, 3)) tick(1'($urandom_range(0, 1)));
        run_write(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                  nack_pick[$urandom_range(0, 3)]);
      end
    end

    // wind down: everything accepted, wait for the last results
    settle();
    $display("run covered %0d input transactions, %0d full write sequences, %0d missed acks",
             offered, writes_done, acks_missing);
    $display("over %0d register settings and four idling mixes with a long output hold-off",
             settings);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
